// File: rtl/core/k_stacks_shared_store_macros.svh
// Assertion macros for the shared stack store.
// Each macro takes a label, the clock, the active-low reset, a trigger and a consequence.
`ifndef K_STACKS_SHARED_STORE_MACROS_SVH
`define K_STACKS_SHARED_STORE_MACROS_SVH

`ifndef SYNTHESIS

`define KSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("shared stack store: same-cycle check failed");

`define KSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("shared stack store: next-cycle check failed");

`else

`define KSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define KSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/kss_pkg.sv
`timescale 1ns / 1ps

package kss_pkg;

	localparam int OUT_W = 32;
	localparam logic [OUT_W-1:0] TOP_EMPTY = '1;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_e;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_OVF   = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_BAD   = 2'd3
	} status_e;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_e;

	typedef struct packed {
		logic             top_valid;
		logic [OUT_W-1:0] top_value;
		logic [OUT_W-1:0] item_value;
		status_e          status;
	} result_t;

endpackage

// File: rtl/core/k_stacks_shared_store.sv
`timescale 1ns / 1ps
// Several LIFO stacks sharing one slot store, linked through a free list.
// Input channel s_*: one push or pop per transaction (s_tuser carries the
// operation and stack number, s_tdata the value to push).
// Output channel m_*: exactly one result transaction per input: status,
// the value pushed or popped, and the addressed stack's top afterwards.
// The accept cycle issues the read of the slot entry (link and value
// underneath); the execute state then modifies and writes it back and
// loads the result register. The slot memory read is registered, so the
// write-back waits for it. s_tready is low while an item sits in the
// execute state, so the next item is taken only after it moves on.
// m_tvalid rises once the execute state hands its result onward.
// A result waits in an output register; while the receiver stalls the
// block still takes one further item and holds it in the execute cycle.
// After reset all stacks are empty and every slot is free; slots never yet
// used are handed out in order by a fill count, so the store needs no
// clearing pass and items are accepted from the first cycle.
module k_stacks_shared_store #(
	parameter int SLOTS      = 16,
	parameter int STACKS     = 4,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // push_data
	input  logic [3:0]  s_tuser,  // operation, stack_index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // item_value, top_value
	output logic [2:0]  m_tuser   // status, top_valid
);

`include "k_stacks_shared_store_macros.svh"

	localparam int AW = $clog2(SLOTS);
	localparam int PW = $clog2(SLOTS + 1);
	localparam int SW = (STACKS > 1) ? $clog2(STACKS) : 1;
	localparam int LW = PW + DATA_WIDTH;
	localparam logic [PW-1:0] NULL_PTR = PW'(SLOTS);

	function automatic logic [kss_pkg::OUT_W-1:0] to_out(input logic [DATA_WIDTH-1:0] v);
		logic [kss_pkg::OUT_W-1:0] r;
		for (int i = 0; i < kss_pkg::OUT_W; i++) begin
			r[i] = v[(i < DATA_WIDTH) ? i : DATA_WIDTH - 1];
		end
		return r;
	endfunction

	kss_pkg::state_e state_q, state_d;

	logic [PW-1:0]         free_head_q, free_head_d;
	logic [PW-1:0]         fresh_q, fresh_d;
	logic [PW-1:0]         top_q [STACKS];
	logic [DATA_WIDTH-1:0] topdata_q [STACKS];

	kss_pkg::op_e          op_s1;
	logic [2:0]            sn_s1;
	logic [DATA_WIDTH-1:0] data_s1;

	logic                  accept;
	logic                  exec_fire;
	logic                  res_ready;
	kss_pkg::op_e          in_op;
	logic [SW-1:0]         in_idx;
	logic [SW-1:0]         sn_idx;
	logic [AW-1:0]         rd_addr;
	logic [LW-1:0]         rd_entry;
	logic [PW-1:0]         rd_link;
	logic [DATA_WIDTH-1:0] rd_below;

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [LW-1:0]         mem_wdata;
	logic                  top_we;
	logic [PW-1:0]         top_wptr;
	logic [DATA_WIDTH-1:0] top_wdata;
	logic                  bad;
	logic [PW-1:0]         cur_top;
	logic [DATA_WIDTH-1:0] cur_data;
	logic                  cur_valid;
	kss_pkg::result_t      res;

	assign in_op    = kss_pkg::op_e'(s_tuser[0]);
	assign in_idx   = s_tuser[SW:1];
	assign sn_idx   = sn_s1[SW-1:0];
	assign s_tready = (state_q == kss_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign exec_fire = (state_q == kss_pkg::ST_EXEC) && res_ready;

	// read the entry the operation will touch: free head on push, top on pop
	assign rd_addr = (in_op == kss_pkg::OP_PUSH) ? free_head_q[AW-1:0] : top_q[in_idx][AW-1:0];
	assign rd_link  = rd_entry[LW-1:DATA_WIDTH];
	assign rd_below = rd_entry[DATA_WIDTH-1:0];

	kss_ram #(
		.WIDTH(LW),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (accept),
		.raddr(rd_addr),
		.rdata(rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kss_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kss_pkg::ST_IDLE: if (s_tvalid) state_d = kss_pkg::ST_EXEC;
			kss_pkg::ST_EXEC: if (res_ready) state_d = kss_pkg::ST_IDLE;
			default:          state_d = kss_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= in_op;
			sn_s1   <= s_tuser[3:1];
			data_s1 <= DATA_WIDTH'(s_tdata);
		end
	end

	always_comb begin
		bad       = {1'b0, sn_s1} >= 4'(STACKS);
		cur_top   = top_q[sn_idx];
		cur_data  = topdata_q[sn_idx];
		cur_valid = cur_top < NULL_PTR;

		free_head_d = free_head_q;
		fresh_d     = fresh_q;
		mem_we      = 1'b0;
		mem_waddr   = free_head_q[AW-1:0];
		mem_wdata   = {cur_top, cur_data};
		top_we      = 1'b0;
		top_wptr    = cur_top;
		top_wdata   = cur_data;

		res.status     = kss_pkg::STAT_OK;
		res.item_value = '0;
		res.top_value  = cur_valid ? to_out(cur_data) : kss_pkg::TOP_EMPTY;
		res.top_valid  = cur_valid;

		priority if (bad) begin
			res.status    = kss_pkg::STAT_BAD;
			res.top_value = '0;
			res.top_valid = 1'b0;
		end else if (op_s1 == kss_pkg::OP_PUSH) begin
			if (free_head_q >= NULL_PTR) begin
				res.status = kss_pkg::STAT_OVF;
			end else begin
				// slots at or beyond the fill count were never used and link in order
				if (free_head_q >= fresh_q) begin
					free_head_d = PW'(free_head_q + PW'(1));
					fresh_d     = PW'(fresh_q + PW'(1));
				end else begin
					free_head_d = rd_link;
				end
				mem_we         = exec_fire;
				mem_waddr      = free_head_q[AW-1:0];
				mem_wdata      = {cur_top, cur_data};
				top_we         = 1'b1;
				top_wptr       = free_head_q;
				top_wdata      = data_s1;
				res.item_value = to_out(data_s1);
				res.top_value  = to_out(data_s1);
				res.top_valid  = 1'b1;
			end
		end else begin
			if (!cur_valid) begin
				res.status = kss_pkg::STAT_EMPTY;
			end else begin
				mem_we         = exec_fire;
				mem_waddr      = cur_top[AW-1:0];
				mem_wdata      = {free_head_q, rd_below};
				free_head_d    = cur_top;
				top_we         = 1'b1;
				top_wptr       = rd_link;
				top_wdata      = rd_below;
				res.item_value = to_out(cur_data);
				res.top_valid  = rd_link < NULL_PTR;
				res.top_value  = (rd_link < NULL_PTR) ? to_out(rd_below) : kss_pkg::TOP_EMPTY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			fresh_q     <= '0;
			for (int i = 0; i < STACKS; i++) begin
				top_q[i] <= NULL_PTR;
			end
		end else if (exec_fire) begin
			free_head_q <= free_head_d;
			fresh_q     <= fresh_d;
			if (top_we) begin
				top_q[sn_idx] <= top_wptr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire && top_we) begin
			topdata_q[sn_idx] <= top_wdata;
		end
	end

	kss_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(state_q == kss_pkg::ST_EXEC),
		.in_ready(res_ready),
		.res     (res),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	`KSS_ASSERT_SAME(a_fresh_range, clk, arst_n, 1'b1, fresh_q <= NULL_PTR)
	`KSS_ASSERT_SAME(a_free_head_known, clk, arst_n, 1'b1,
		(free_head_q == NULL_PTR) || (free_head_q <= fresh_q))
	`KSS_ASSERT_SAME(a_push_leaves_top, clk, arst_n,
		exec_fire && (op_s1 == kss_pkg::OP_PUSH) && (res.status == kss_pkg::STAT_OK),
		res.top_valid)
	`KSS_ASSERT_NEXT(a_fresh_only_on_push, clk, arst_n,
		!(exec_fire && (op_s1 == kss_pkg::OP_PUSH)), $stable(fresh_q))

endmodule

// File: rtl/core/kss_ram.sv
`timescale 1ns / 1ps

module kss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/kss_out.sv
`timescale 1ns / 1ps

module kss_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  kss_pkg::result_t res,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [63:0]      m_tdata,  // item_value, top_value
	output logic [2:0]       m_tuser   // status, top_valid
);

	logic             valid_q;
	kss_pkg::result_t res_q;

	// take a new result when empty or when the held one leaves this cycle
	assign in_ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {res_q.top_value, res_q.item_value};
	assign m_tuser  = {res_q.top_valid, res_q.status};

endmodule

// File: dv/k_stacks_shared_store_checker.sv
`timescale 1ns / 1ps

module k_stacks_shared_store_checker
	import kss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,  // push_data
	input  logic [3:0]  s_tuser,  // operation, stack_index
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,  // item_value, top_value
	input  logic [2:0]  m_tuser,  // status, top_valid
	output int          mismatches,
	output int          pending
);

	localparam int SLOTS  = 16;
	localparam int STACKS = 4;
	localparam logic [4:0] NIL = 5'(SLOTS);

	typedef struct packed {
		status_e     status;
		logic [31:0] item_value;
		logic [31:0] top_value;
		logic        top_valid;
	} stack_result_t;

	logic [31:0]   slot_val [SLOTS];
	logic [4:0]    slot_next [SLOTS];
	logic [4:0]    top_ptr [STACKS];
	logic [4:0]    free_ptr;
	stack_result_t expected_results [$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("ERROR %0t: %s got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	// Fill in the top of one stack; a pointer at or beyond SLOTS is null.
	function automatic stack_result_t with_top(input stack_result_t r, input logic [1:0] s);
		stack_result_t o;
		o = r;
		if (top_ptr[s] < NIL) begin
			o.top_value = slot_val[top_ptr[s][3:0]];
			o.top_valid = 1'b1;
		end else begin
			o.top_value = TOP_EMPTY;
			o.top_valid = 1'b0;
		end
		return o;
	endfunction

	task automatic predict_stack_op(input op_e op, input logic [2:0] idx,
			input logic [31:0] val);
		stack_result_t r;
		logic [4:0]    slot;
		logic [1:0]    s;
		r = '{status: STAT_OK, item_value: '0, top_value: '0, top_valid: 1'b0};
		s = idx[1:0];
		if (idx >= STACKS) begin
			r.status = STAT_BAD;
		end else if (op == OP_PUSH) begin
			slot = free_ptr;
			if (slot >= NIL) begin
				r.status = STAT_OVF;
			end else begin
				free_ptr = slot_next[slot[3:0]];
				slot_val[slot[3:0]] = val;
				slot_next[slot[3:0]] = top_ptr[s];
				top_ptr[s] = slot;
				r.item_value = val;
			end
			r = with_top(r, s);
		end else begin
			slot = top_ptr[s];
			if (slot >= NIL) begin
				r.status = STAT_EMPTY;
			end else begin
				r.item_value = slot_val[slot[3:0]];
				top_ptr[s] = slot_next[slot[3:0]];
				slot_next[slot[3:0]] = free_ptr;
				free_ptr = slot;
			end
			r = with_top(r, s);
		end
		expected_results.push_back(r);
	endtask

	task automatic check_result();
		stack_result_t want;
		if (expected_results.size() == 0) begin
			$display("ERROR %0t: result transaction with nothing outstanding", $time);
			mismatches++;
		end else begin
			want = expected_results.pop_front();
			if (m_tuser[1:0] !== want.status)
				report_mismatch("status", 32'(m_tuser[1:0]), 32'(want.status));
			if (m_tdata[31:0] !== want.item_value)
				report_mismatch("item_value", m_tdata[31:0], want.item_value);
			if (m_tdata[63:32] !== want.top_value)
				report_mismatch("top_value", m_tdata[63:32], want.top_value);
			if (m_tuser[2] !== want.top_valid)
				report_mismatch("top_valid", 32'(m_tuser[2]), 32'(want.top_valid));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_val[i] = '0;
				slot_next[i] = (i + 1 < SLOTS) ? 5'(i + 1) : NIL;
			end
			for (int i = 0; i < STACKS; i++)
				top_ptr[i] = NIL;
			free_ptr = '0;
			expected_results.delete();
			pending = 0;
			mismatches = 0;
		end else begin
			// Retire first: a result never belongs to an item taken at the same edge.
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				predict_stack_op(op_e'(s_tuser[0]), s_tuser[3:1], s_tdata);
			pending = expected_results.size();
		end
	end

endmodule

// File: dv/k_stacks_shared_store_tb.sv
`timescale 1ns / 1ps

module k_stacks_shared_store_tb;
	import kss_pkg::*;

	localparam int PHASE_ITEMS = 288;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // push_data
	logic [3:0]  s_tuser = '0;   // operation, stack_index
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // item_value, top_value
	logic [2:0]  m_tuser;        // status, top_valid
	int          mismatches;
	int          pending;
	int          idle_pct = 0;
	int          stall_pct = 0;

	k_stacks_shared_store dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	k_stacks_shared_store_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// Drive one transaction and hold it until the block takes it.
	task automatic send_stack_op(input op_e op, input logic [2:0] idx, input logic [31:0] val);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= {idx, op};
		s_tdata <= val;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic random_stack_ops(input int count);
		int          push_pct;
		op_e         op;
		logic [2:0]  idx;
		logic [31:0] val;
		push_pct = 50;
		for (int n = 0; n < count; n++) begin
			// Swing between filling and draining so the store hits full and empty.
			if (n % 40 == 0) begin
				case ($urandom_range(2))
					0: push_pct = 15;
					1: push_pct = 50;
					default: push_pct = 85;
				endcase
			end
			op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
			idx = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 4)) : 3'($urandom_range(3));
			case ($urandom_range(15))
				0: val = 32'h8000_0000;
				1: val = 32'h7fff_ffff;
				2: val = '0;
				3: val = '1;
				default: val = $urandom;
			endcase
			send_stack_op(op, idx, val);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty pops, bad stack numbers, extreme values
		for (int s = 0; s < 4; s++)
			send_stack_op(OP_POP, 3'(s), $urandom);
		send_stack_op(OP_PUSH, 3'd4, 32'h1234_5678);
		send_stack_op(OP_POP, 3'd7, '0);
		send_stack_op(OP_PUSH, 3'd0, 32'h8000_0000);
		send_stack_op(OP_PUSH, 3'd0, 32'h7fff_ffff);
		send_stack_op(OP_POP, 3'd0, '0);
		// Use up every free slot, leaving stack 3 empty, then overflow
		for (int i = 0; i < 15; i++)
			send_stack_op(OP_PUSH, 3'(i % 3), (i == 0) ? 32'hffff_ffff : $urandom);
		send_stack_op(OP_PUSH, 3'd3, 32'h0bad_0bad);
		send_stack_op(OP_PUSH, 3'd1, 32'h5555_aaaa);

		random_stack_ops(PHASE_ITEMS);
		idle_pct = 88;
		random_stack_ops(PHASE_ITEMS);
		idle_pct = 0;
		stall_pct = 88;
		random_stack_ops(PHASE_ITEMS);
		idle_pct = 6;
		stall_pct = 6;
		random_stack_ops(PHASE_ITEMS);

		s_tvalid <= 1'b0;
		stall_pct = 0;
		wait (pending == 0);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
